### hdl/arm_pkg.sv
// Shared types and constants for the audio route mixer.
package arm_pkg;

	localparam int OP_W       = 3;
	localparam int SLOT_W     = 6;
	localparam int SAMPLE_W   = 24;
	localparam int RIDX_W     = 7;
	localparam int GAIN_W     = 16;
	localparam int GAIN_FRAC  = 12;
	localparam int RCOUNT_W   = 8;
	localparam int ROUTE_W    = 2 * SLOT_W + GAIN_W;
	localparam int EXT_W      = 34;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	localparam int SLOTS_DEF       = 64;
	localparam int ROUTES_DEF      = 128;
	localparam int SAMPLE_BITS_DEF = 24;

	localparam logic REG_ROUTE_COUNT = 1'b0;

	typedef enum logic [OP_W-1:0] {
		OP_SET_ROUTE  = 3'd0,
		OP_CLEAR      = 3'd1,
		OP_WRITE_SLOT = 3'd2,
		OP_MIX        = 3'd3,
		OP_READ_SLOT  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_MIX_RT,
		S_MIX_SRC,
		S_MIX_MUL,
		S_MIX_ACC,
		S_DONE
	} ctl_state_t;

	typedef struct packed {
		logic latch;
		logic route_wr;
		logic clear;
		logic slot_wr;
		logic rd_issue;
		logic rd_capture;
		logic mix_start;
		logic rt_rd;
		logic sl_rd;
		logic mul;
		logic acc;
		logic cnt_inc;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic mix_done;
		logic route_skip;
		logic out_free;
	} ctl_sts_t;

endpackage

### hdl/arm_if.sv
// Item and result channel interfaces of the audio route mixer.
interface arm_item_if;
	logic                             valid;
	logic                             ready;
	logic [arm_pkg::OP_W-1:0]         operation;
	logic [arm_pkg::SLOT_W-1:0]       slot;
	logic signed [arm_pkg::SAMPLE_W-1:0] sample_in;
	logic [arm_pkg::RIDX_W-1:0]       route_index;
	logic [arm_pkg::SLOT_W-1:0]       source_slot;
	logic [arm_pkg::SLOT_W-1:0]       dest_slot;
	logic signed [arm_pkg::GAIN_W-1:0] gain;

	modport source (output valid, operation, slot, sample_in, route_index, source_slot,
		dest_slot, gain, input ready);
	modport sink (input valid, operation, slot, sample_in, route_index, source_slot,
		dest_slot, gain, output ready);
endinterface

interface arm_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [arm_pkg::SAMPLE_W-1:0] sample_out;
	logic                                saturated;

	modport source (output valid, sample_out, saturated, input ready);
	modport sink (input valid, sample_out, saturated, output ready);
endinterface

### hdl/arm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module arm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/arm_ctrl.sv
// Sequencing state machine of the audio route mixer.
module arm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  arm_pkg::ctl_sts_t sts,
	output arm_pkg::ctl_cmd_t cmd
);

	arm_pkg::ctl_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arm_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			arm_pkg::S_IDLE: begin
				if (in_valid) state_nx = arm_pkg::S_EXEC;
			end
			arm_pkg::S_EXEC: begin
				case (sts.op)
					arm_pkg::OP_MIX:       state_nx = arm_pkg::S_MIX_RT;
					arm_pkg::OP_READ_SLOT: state_nx = arm_pkg::S_READ;
					default:               state_nx = arm_pkg::S_DONE;
				endcase
			end
			arm_pkg::S_READ:    state_nx = arm_pkg::S_DONE;
			arm_pkg::S_MIX_RT: begin
				state_nx = sts.mix_done ? arm_pkg::S_DONE : arm_pkg::S_MIX_SRC;
			end
			arm_pkg::S_MIX_SRC: begin
				state_nx = sts.route_skip ? arm_pkg::S_MIX_RT : arm_pkg::S_MIX_MUL;
			end
			arm_pkg::S_MIX_MUL: state_nx = arm_pkg::S_MIX_ACC;
			arm_pkg::S_MIX_ACC: state_nx = arm_pkg::S_MIX_RT;
			arm_pkg::S_DONE: begin
				if (sts.out_free) state_nx = arm_pkg::S_IDLE;
			end
			default:            state_nx = arm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			arm_pkg::S_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
			end
			arm_pkg::S_EXEC: begin
				case (sts.op)
					arm_pkg::OP_SET_ROUTE:  cmd.route_wr  = 1'b1;
					arm_pkg::OP_CLEAR:      cmd.clear     = 1'b1;
					arm_pkg::OP_WRITE_SLOT: cmd.slot_wr   = 1'b1;
					arm_pkg::OP_MIX:        cmd.mix_start = 1'b1;
					arm_pkg::OP_READ_SLOT:  cmd.rd_issue  = 1'b1;
					default: ;
				endcase
			end
			arm_pkg::S_READ:    cmd.rd_capture = 1'b1;
			arm_pkg::S_MIX_RT:  cmd.rt_rd = !sts.mix_done;
			arm_pkg::S_MIX_SRC: begin
				cmd.sl_rd   = !sts.route_skip;
				cmd.cnt_inc = sts.route_skip;
			end
			arm_pkg::S_MIX_MUL: cmd.mul = 1'b1;
			arm_pkg::S_MIX_ACC: begin
				cmd.acc     = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			arm_pkg::S_DONE:    cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free) else $error("result loaded while output busy");

	a_acc_loop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == arm_pkg::S_MIX_ACC) |=> (state_q == arm_pkg::S_MIX_RT))
		else $error("accumulate not followed by next route");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.route_wr, cmd.clear, cmd.slot_wr, cmd.acc}))
		else $error("conflicting store writes");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch |=> (state_q == arm_pkg::S_EXEC))
		else $error("transaction accepted without execution");

endmodule

### hdl/arm_datapath.sv
// Slot store, route table, multiply-accumulate and result register.
module arm_datapath #(
	parameter int SLOTS       = arm_pkg::SLOTS_DEF,
	parameter int ROUTES      = arm_pkg::ROUTES_DEF,
	parameter int SAMPLE_BITS = arm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [arm_pkg::OP_W-1:0]            operation,
	input  logic [arm_pkg::SLOT_W-1:0]          slot,
	input  logic signed [arm_pkg::SAMPLE_W-1:0] sample_in,
	input  logic [arm_pkg::RIDX_W-1:0]          route_index,
	input  logic [arm_pkg::SLOT_W-1:0]          source_slot,
	input  logic [arm_pkg::SLOT_W-1:0]          dest_slot,
	input  logic signed [arm_pkg::GAIN_W-1:0]   gain,
	input  logic [arm_pkg::RCOUNT_W-1:0]        route_count,
	input  arm_pkg::ctl_cmd_t                   cmd,
	output arm_pkg::ctl_sts_t                   sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [arm_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                saturated
);

	localparam int SW  = SAMPLE_BITS;
	localparam int SAW = $clog2(SLOTS);
	localparam int RAW = (ROUTES > 1) ? $clog2(ROUTES) : 1;
	localparam int PW  = SW + arm_pkg::GAIN_W;
	localparam int QW  = PW - arm_pkg::GAIN_FRAC;
	localparam int AW  = QW + 1;
	localparam int XW  = arm_pkg::EXT_W;
	localparam int CW  = arm_pkg::RCOUNT_W;

	localparam logic signed [AW-1:0] ACC_MAX = AW'((64'sd1 <<< (SW - 1)) - 64'sd1);
	localparam logic signed [AW-1:0] ACC_MIN = ~ACC_MAX;
	localparam logic signed [XW-1:0] WR_MAX  = XW'((64'sd1 <<< (SW - 1)) - 64'sd1);
	localparam logic signed [XW-1:0] WR_MIN  = ~WR_MAX;
	localparam logic signed [XW-1:0] RD_MAX  =
		XW'((64'sd1 <<< (arm_pkg::SAMPLE_W - 1)) - 64'sd1);
	localparam logic signed [XW-1:0] RD_MIN  = ~RD_MAX;

	// latched transaction
	arm_pkg::op_t                          op_q;
	logic [arm_pkg::SLOT_W-1:0]            slot_q;
	logic signed [arm_pkg::SAMPLE_W-1:0]   sample_q;
	logic [arm_pkg::RIDX_W-1:0]            ridx_q;
	logic [arm_pkg::SLOT_W-1:0]            src_q;
	logic [arm_pkg::SLOT_W-1:0]            dst_q;
	logic signed [arm_pkg::GAIN_W-1:0]     gain_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q     <= arm_pkg::op_t'(operation);
			slot_q   <= slot;
			sample_q <= sample_in;
			ridx_q   <= route_index;
			src_q    <= source_slot;
			dst_q    <= dest_slot;
			gain_q   <= gain;
		end
	end

	// route table
	logic [arm_pkg::ROUTE_W-1:0]       rt_rdata;
	logic [CW-1:0]                     cnt_q;
	logic [CW-1:0]                     eff_n;
	logic                              ridx_ok;
	logic [arm_pkg::SLOT_W-1:0]        rt_src;
	logic [arm_pkg::SLOT_W-1:0]        rt_dst;
	logic signed [arm_pkg::GAIN_W-1:0] rt_gain;
	logic                              route_skip;

	assign ridx_ok = 32'(ridx_q) < ROUTES;

	arm_ram #(.WIDTH(arm_pkg::ROUTE_W), .DEPTH(ROUTES)) u_route_ram (
		.clk   (clk),
		.we    (cmd.route_wr && ridx_ok),
		.waddr (RAW'(ridx_q)),
		.wdata ({src_q, dst_q, gain_q}),
		.re    (cmd.rt_rd),
		.raddr (RAW'(cnt_q)),
		.rdata (rt_rdata)
	);

	assign rt_src  = rt_rdata[arm_pkg::ROUTE_W-1 -: arm_pkg::SLOT_W];
	assign rt_dst  = rt_rdata[arm_pkg::GAIN_W +: arm_pkg::SLOT_W];
	assign rt_gain = rt_rdata[arm_pkg::GAIN_W-1:0];
	assign route_skip = (32'(rt_src) >= SLOTS) || (32'(rt_dst) >= SLOTS);

	assign eff_n = (32'(route_count) > ROUTES) ? CW'(ROUTES) : route_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.mix_start) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	// slot store: two copies for source and destination reads
	logic [SLOTS-1:0]       slot_vld_q;
	logic                   slot_ok;
	logic                   st_we;
	logic [SAW-1:0]         st_waddr;
	logic signed [SW-1:0]   st_wdata;
	logic [SAW-1:0]         a_raddr;
	logic [SW-1:0]          a_rdata;
	logic [SW-1:0]          b_rdata;
	logic                   src_vld_q;
	logic                   dst_vld_q;
	logic signed [SW-1:0]   src_val;
	logic signed [SW-1:0]   dst_val;
	logic signed [XW-1:0]   win_x;
	logic signed [SW-1:0]   win_c;
	logic signed [AW-1:0]   sum;
	logic signed [SW-1:0]   acc_c;
	logic                   acc_hit;

	assign slot_ok  = 32'(slot_q) < SLOTS;
	assign st_we    = cmd.acc || (cmd.slot_wr && slot_ok);
	assign st_waddr = cmd.acc ? SAW'(rt_dst) : SAW'(slot_q);
	assign st_wdata = cmd.acc ? acc_c : win_c;
	assign a_raddr  = cmd.rd_issue ? SAW'(slot_q) : SAW'(rt_src);

	arm_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_slot_ram_a (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (cmd.rd_issue || cmd.sl_rd),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	arm_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_slot_ram_b (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (cmd.sl_rd),
		.raddr (SAW'(rt_dst)),
		.rdata (b_rdata)
	);

	// unwritten slots read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
		end else if (cmd.clear) begin
			slot_vld_q <= '0;
		end else if (st_we) begin
			slot_vld_q[st_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			src_vld_q <= slot_ok && slot_vld_q[SAW'(slot_q)];
		end else if (cmd.sl_rd) begin
			src_vld_q <= slot_vld_q[SAW'(rt_src)];
			dst_vld_q <= slot_vld_q[SAW'(rt_dst)];
		end
	end

	assign src_val = src_vld_q ? a_rdata : '0;
	assign dst_val = dst_vld_q ? b_rdata : '0;

	// write clamp
	assign win_x = XW'(sample_q);
	always_comb begin
		if (win_x > WR_MAX) begin
			win_c = SW'(WR_MAX);
		end else if (win_x < WR_MIN) begin
			win_c = SW'(WR_MIN);
		end else begin
			win_c = SW'(win_x);
		end
	end

	// multiply, then floor shift, add and saturate
	logic signed [PW-1:0] prod_q;
	logic signed [QW-1:0] q_val;
	logic                 sat_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= PW'(src_val) * PW'(rt_gain);
		end
	end

	assign q_val = prod_q[PW-1:arm_pkg::GAIN_FRAC];
	assign sum   = AW'(dst_val) + AW'(q_val);

	always_comb begin
		acc_hit = 1'b0;
		if (sum > ACC_MAX) begin
			acc_c   = SW'(ACC_MAX);
			acc_hit = 1'b1;
		end else if (sum < ACC_MIN) begin
			acc_c   = SW'(ACC_MIN);
			acc_hit = 1'b1;
		end else begin
			acc_c = SW'(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (cmd.mix_start) begin
			sat_q <= 1'b0;
		end else if (cmd.acc && acc_hit) begin
			sat_q <= 1'b1;
		end
	end

	// read clamp
	logic signed [XW-1:0]                rd_x;
	logic signed [arm_pkg::SAMPLE_W-1:0] rd_c;
	logic signed [arm_pkg::SAMPLE_W-1:0] rd_res_q;

	assign rd_x = XW'(src_val);
	always_comb begin
		if (rd_x > RD_MAX) begin
			rd_c = arm_pkg::SAMPLE_W'(RD_MAX);
		end else if (rd_x < RD_MIN) begin
			rd_c = arm_pkg::SAMPLE_W'(RD_MIN);
		end else begin
			rd_c = arm_pkg::SAMPLE_W'(rd_x);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_capture) begin
			rd_res_q <= rd_c;
		end
	end

	// result register
	logic                                out_vld_q;
	logic signed [arm_pkg::SAMPLE_W-1:0] sample_out_q;
	logic                                sat_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sample_out_q <= (op_q == arm_pkg::OP_READ_SLOT) ? rd_res_q : '0;
			sat_out_q    <= (op_q == arm_pkg::OP_MIX) ? sat_q : 1'b0;
		end
	end

	assign out_valid  = out_vld_q;
	assign sample_out = sample_out_q;
	assign saturated  = sat_out_q;

	assign sts.op         = op_q;
	assign sts.mix_done   = cnt_q >= eff_n;
	assign sts.route_skip = route_skip;
	assign sts.out_free   = !out_vld_q || out_ready;

	a_acc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |-> !route_skip) else $error("accumulate on out-of-range route");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rt_rd |-> (cnt_q < eff_n)) else $error("route read past route count");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (slot_vld_q == '0)) else $error("clear left slots valid");

endmodule

### hdl/audio_route_mixer_top.sv
// Top level of the audio route mixer: channels, APB register and core.
// One transaction in, one result out, one transaction at a time. mix walks
// n = min(route_count, ROUTES) routes, and each route steps through a route
// table read, two slot store reads, a registered multiply and a saturating
// write-back. Routes with a source or destination outside the store skip the
// slot reads, multiply and write-back. The slot store reads as zero after
// reset and after clear through per-slot valid flags, so there is no clearing
// pass. route_count is at byte address 0; the user must write it only while
// the block is idle, which the block itself does not enforce.
module audio_route_mixer_top #(
	parameter int SLOTS       = arm_pkg::SLOTS_DEF,
	parameter int ROUTES      = arm_pkg::ROUTES_DEF,
	parameter int SAMPLE_BITS = arm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	arm_item_if.sink                    item,
	arm_result_if.source                result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [arm_pkg::APB_AW-1:0]  paddr,
	input  logic [arm_pkg::APB_DW-1:0]  pwdata,
	output logic [arm_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	logic [arm_pkg::RCOUNT_W-1:0] route_count_q;
	logic                         reg_sel;
	logic                         in_ready;
	arm_pkg::ctl_cmd_t            cmd;
	arm_pkg::ctl_sts_t            sts;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2] == arm_pkg::REG_ROUTE_COUNT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_count_q <= '0;
		end else if (psel && penable && pwrite && reg_sel) begin
			route_count_q <= pwdata[arm_pkg::RCOUNT_W-1:0];
		end
	end

	assign prdata = reg_sel ? arm_pkg::APB_DW'(route_count_q) : '0;

	assign item.ready = in_ready;

	arm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	arm_datapath #(
		.SLOTS       (SLOTS),
		.ROUTES      (ROUTES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.operation   (item.operation),
		.slot        (item.slot),
		.sample_in   (item.sample_in),
		.route_index (item.route_index),
		.source_slot (item.source_slot),
		.dest_slot   (item.dest_slot),
		.gain        (item.gain),
		.route_count (route_count_q),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.sample_out  (result.sample_out),
		.saturated   (result.saturated)
	);

endmodule
